FILE: rtl/core/fcull_pkg.sv
// Shared types and codes for the frustum culling block.
package fcull_pkg;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_POINT  = 2'd1;
  localparam logic [1:0] ACT_SPHERE = 2'd2;
  localparam logic [1:0] ACT_BOX    = 2'd3;

  localparam logic [1:0] DEC_FAIL  = 2'd0;
  localparam logic [1:0] DEC_PLANE = 2'd1;
  localparam logic [1:0] DEC_BOX   = 2'd2;

  localparam int BOUND_SLOTS  = 6;
  localparam int CORNER_COUNT = 8;
  localparam int ACC_W        = 68;

  typedef struct packed {
    logic        [1:0]  action;
    logic        [4:0]  slot;
    logic signed [31:0] load_value;
    logic signed [31:0] x_lo;
    logic signed [31:0] y_lo;
    logic signed [31:0] z_lo;
    logic signed [31:0] x_hi;
    logic signed [31:0] y_hi;
    logic signed [31:0] z_hi;
    logic signed [31:0] radius;
  } cull_in_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] decided_by;
  } cull_out_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

endpackage

FILE: rtl/core/frustum_cull_point_sphere_box_top.sv
// Frustum culling top level: item latch, sequencer and result register.
// Each plane test runs MUL and ACC for each of the three terms, then FIN;
// box tests repeat this per corner and end in an overlap check if none passes.
// One shared 32x32 multiplier does all products; busy stays high meanwhile.
// Loads complete in the accept cycle and give no result word.
// Synchronous reset clears all coefficients and bounds to zero; results
// are strobed for one cycle and cannot be stalled.
module frustum_cull_point_sphere_box_top import fcull_pkg::*; #(
  parameter int PLANE_COUNT = 6,
  parameter int FRAC_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  cull_in_t  in_data,
  output logic      out_valid,
  output cull_out_t out_data
);

  localparam int PW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OVL  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] plane_r, plane_nxt;
  logic [1:0]    term_r, term_nxt;
  logic [2:0]    corner_r, corner_nxt;
  cull_in_t      item_r;
  cull_out_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic               accept;
  logic               wr_en;
  logic signed [31:0] coef_rd, d_rd;
  logic [5:0][31:0]   bounds;
  logic signed [31:0] cx, cy, cz, mul_b, thr;
  logic signed [32:0] offs;
  logic               positive;
  logic               overlap;
  mac_ctrl_t          ctrl;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (in_data.action == ACT_LOAD);

  fcull_store #(.PLANE_COUNT(PLANE_COUNT), .PW(PW)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_slot  (in_data.slot),
    .wr_data  (in_data.load_value),
    .rd_plane (plane_r),
    .rd_term  (term_r),
    .coef_rd  (coef_rd),
    .d_rd     (d_rd),
    .bounds   (bounds)
  );

  // corner bits: x from bit 2, y from bit 1, z from bit 0
  assign cx = corner_r[2] ? item_r.x_hi : item_r.x_lo;
  assign cy = corner_r[1] ? item_r.y_hi : item_r.y_lo;
  assign cz = corner_r[0] ? item_r.z_hi : item_r.z_lo;

  always_comb begin
    case (term_r)
      2'd0:    mul_b = cx;
      2'd1:    mul_b = cy;
      default: mul_b = cz;
    endcase
  end

  assign thr  = (item_r.action == ACT_SPHERE) ? item_r.radius : 32'sd0;
  assign offs = {d_rd[31], d_rd} - {thr[31], thr};

  assign ctrl.mul_en    = (state_r == ST_MUL);
  assign ctrl.acc_en    = (state_r == ST_ACC);
  assign ctrl.acc_first = (term_r == 2'd0);

  fcull_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .mul_a    (coef_rd),
    .mul_b    (mul_b),
    .offs     (offs),
    .positive (positive)
  );

  // inclusive overlap against the frustum box
  always_comb begin
    overlap = 1'b1;
    if (item_r.x_hi < $signed(bounds[0]) || item_r.x_lo > $signed(bounds[3])) overlap = 1'b0;
    if (item_r.y_hi < $signed(bounds[1]) || item_r.y_lo > $signed(bounds[4])) overlap = 1'b0;
    if (item_r.z_hi < $signed(bounds[2]) || item_r.z_lo > $signed(bounds[5])) overlap = 1'b0;
  end

  always_comb begin
    state_nxt     = state_r;
    plane_nxt     = plane_r;
    term_nxt      = term_r;
    corner_nxt    = corner_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.action != ACT_LOAD) begin
          state_nxt  = ST_MUL;
          plane_nxt  = '0;
          term_nxt   = 2'd0;
          corner_nxt = 3'd0;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (term_r == 2'd2) begin
          state_nxt = ST_FIN;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        term_nxt = 2'd0;
        if (positive) begin
          if (plane_r == PW'(PLANE_COUNT - 1)) begin
            out_nxt       = '{visible: 1'b1, decided_by: DEC_PLANE};
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            plane_nxt = plane_r + PW'(1);
            state_nxt = ST_MUL;
          end
        end else if (item_r.action == ACT_BOX) begin
          if (corner_r == 3'(CORNER_COUNT - 1)) begin
            state_nxt = ST_OVL;
          end else begin
            corner_nxt = corner_r + 3'd1;
            plane_nxt  = '0;
            state_nxt  = ST_MUL;
          end
        end else begin
          out_nxt       = '{visible: 1'b0, decided_by: DEC_FAIL};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_OVL: begin
        out_nxt.visible    = overlap;
        out_nxt.decided_by = overlap ? DEC_BOX : DEC_FAIL;
        out_valid_nxt      = 1'b1;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      plane_r     <= '0;
      term_r      <= 2'd0;
      corner_r    <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      plane_r     <= plane_nxt;
      term_r      <= term_nxt;
      corner_r    <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      item_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/fcull_store.sv
// Plane coefficient and frustum bound register file.
module fcull_store import fcull_pkg::*; #(
  parameter int PLANE_COUNT = 6,
  parameter int PW = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [4:0]             wr_slot,
  input  logic [31:0]            wr_data,
  input  logic [PW-1:0]          rd_plane,
  input  logic [1:0]             rd_term,
  output logic signed [31:0]     coef_rd,
  output logic signed [31:0]     d_rd,
  output logic [5:0][31:0]       bounds
);

  localparam int COEF_SLOTS = PLANE_COUNT * 4;

  logic [3:0][31:0] coef_r [PLANE_COUNT];
  logic [5:0][31:0] bounds_r;
  logic [5:0]       slot6;
  logic [5:0]       bidx6;

  assign slot6 = {1'b0, wr_slot};
  assign bidx6 = slot6 - 6'(COEF_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        coef_r[p] <= '0;
      end
      bounds_r <= '0;
    end else if (wr_en) begin
      if (slot6 < 6'(COEF_SLOTS)) begin
        coef_r[wr_slot[PW+1:2]][wr_slot[1:0]] <= wr_data;
      end else if (slot6 < 6'(COEF_SLOTS + BOUND_SLOTS)) begin
        bounds_r[bidx6[2:0]] <= wr_data;
      end
    end
  end

  assign coef_rd = coef_r[rd_plane][rd_term];
  assign d_rd    = coef_r[rd_plane][3];
  assign bounds  = bounds_r;

endmodule

FILE: rtl/core/fcull_mac.sv
// Shared multiply-accumulate unit with plane sign check.
module fcull_mac import fcull_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  mac_ctrl_t          ctrl,
  input  logic signed [31:0] mul_a,
  input  logic signed [31:0] mul_b,
  input  logic signed [32:0] offs,
  output logic               positive
);

  logic signed [63:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] fin_sum;

  assign acc_base = ctrl.acc_first ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctrl.acc_en) begin
      acc_r <= acc_base + ACC_W'(prod_r);
    end
  end

  // add offset minus threshold, shifted left by FRAC_BITS to the product scale
  assign fin_sum  = acc_r + (ACC_W'(offs) <<< FRAC_BITS);
  assign positive = !fin_sum[ACC_W-1] && (|fin_sum);

endmodule
